// ----- sv/trrld_pkg.sv -----
// Shared types and codes of the typed round-robin lane dispatcher.
package trrld_pkg;

	localparam logic [1:0] KIND_OK      = 2'd0;
	localparam logic [1:0] KIND_NO_LANE = 2'd1;
	localparam logic [1:0] KIND_FULL    = 2'd2;
	localparam logic [1:0] KIND_GRANT   = 2'd3;

	localparam logic [1:0] REG_LANE_COUNT = 2'd0;
	localparam logic [1:0] REG_LANE_CAPS  = 2'd1;
	localparam logic [1:0] REG_A_TICKS    = 2'd2;
	localparam logic [1:0] REG_B_TICKS    = 2'd3;

	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic accept_in;
		logic do_enq;
		logic lane_clr;
		logic scan_step;
		logic take_data;
		logic flush;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;
		logic grant_now;
		logic lane_last;
		logic out_free;
		logic pend_valid;
	} sts_t;

endpackage

// ----- sv/trrld_ctrl.sv -----
// Sequencer of the lane dispatcher: enqueue, per-lane tick scan and result flush.
module trrld_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  trrld_pkg::sts_t   sts,
	output trrld_pkg::cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENQ,
		ST_SCAN,
		ST_RDATA,
		ST_FLUSH
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.accept_in = in_valid;
				cmd.lane_clr  = in_valid;
			end
			ST_ENQ:   cmd.do_enq = sts.out_free;
			ST_SCAN:  cmd.scan_step = 1'b1;
			ST_RDATA: cmd.take_data = sts.out_free || !sts.pend_valid;
			ST_FLUSH: cmd.flush = sts.pend_valid && sts.out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= sts.is_tick ? ST_SCAN : ST_ENQ;
				end
				ST_ENQ: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (sts.grant_now) state_q <= ST_RDATA;
					else if (sts.lane_last) state_q <= ST_FLUSH;
				end
				ST_RDATA: begin
					if (sts.out_free || !sts.pend_valid)
						state_q <= sts.lane_last ? ST_FLUSH : ST_SCAN;
				end
				ST_FLUSH: begin
					if (!sts.pend_valid || sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/trrld_dp.sv -----
// Datapath of the lane dispatcher: registers, lane queues, queue memory, result registers.
module trrld_dp #(
	parameter int MAX_LANES   = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  trrld_pkg::cmd_t   cmd,
	output trrld_pkg::sts_t   sts,
	input  logic              in_cmd,
	input  logic              in_cls,
	input  logic              in_urg,
	input  logic [15:0]       in_tag,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        out_kind,
	output logic [2:0]        out_lane,
	output logic [15:0]       out_tag,
	output logic              out_cls,
	output logic              out_last
);

	localparam int LW    = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
	localparam int QW    = $clog2(QUEUE_DEPTH);
	localparam int FW    = $clog2(QUEUE_DEPTH + 1);
	localparam int DEPTH = MAX_LANES * QUEUE_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [3:0]    MAX_N  = 4'(MAX_LANES);
	localparam logic [AW-1:0] QD_A   = AW'(QUEUE_DEPTH);
	localparam logic [QW-1:0] QD_TOP = QW'(QUEUE_DEPTH - 1);
	localparam logic [FW-1:0] QD_F   = FW'(QUEUE_DEPTH);

	logic [3:0]  lane_count_q;
	logic [15:0] caps_q, a_ticks_q, b_ticks_q;
	logic [2:0]  a_ptr_q, b_ptr_q;
	logic [QW-1:0] head_q [MAX_LANES];
	logic [QW-1:0] tail_q [MAX_LANES];
	logic [FW-1:0] fill_q [MAX_LANES];
	logic [15:0]   busy_q [MAX_LANES];
	logic [17:0]   mem [DEPTH];
	logic [17:0]   rd_q;

	logic        icls_q, iurg_q;
	logic [15:0] itag_q;
	logic [LW-1:0] lane_q;

	logic        pend_q;
	logic [LW-1:0] pend_lane_q;
	logic [15:0] pend_tag_q;
	logic        pend_cls_q;

	logic [3:0]  n_act;
	logic [MAX_LANES-1:0] cm;
	logic [2:0]  p_eff;
	logic        hi_f, lo_f, found;
	logic [LW-1:0] hi_l, lo_l, lane_e;
	logic [2:0]  ptr_nx;
	logic [15:0] busy_dec;
	logic [QW-1:0] head_nx;
	logic [AW-1:0] rd_addr, wr_addr;
	logic        out_free, out_load;

	always_comb begin
		if (lane_count_q == 4'd0) n_act = 4'd1;
		else if (lane_count_q > MAX_N) n_act = MAX_N;
		else n_act = lane_count_q;
	end

	// compatible lanes, round-robin pick and lowest-lane pick for urgent class A
	always_comb begin
		p_eff = ({1'b0, (icls_q ? a_ptr_q : b_ptr_q)} < n_act) ?
			(icls_q ? a_ptr_q : b_ptr_q) : 3'd0;
		hi_f = 1'b0; lo_f = 1'b0; hi_l = '0; lo_l = '0;
		for (int i = 0; i < MAX_LANES; i++) begin
			cm[i] = (4'(i) < n_act) && caps_q[2*i + (icls_q ? 0 : 1)];
			if (cm[i] && !lo_f) begin
				lo_f = 1'b1; lo_l = LW'(i);
			end
			if (cm[i] && !hi_f && (3'(i) >= p_eff)) begin
				hi_f = 1'b1; hi_l = LW'(i);
			end
		end
		found  = lo_f;
		lane_e = (iurg_q && icls_q) ? lo_l : (hi_f ? hi_l : lo_l);
		if (!found) ptr_nx = p_eff;
		else if (4'(lane_e) + 4'd1 == n_act) ptr_nx = 3'd0;
		else ptr_nx = 3'(lane_e) + 3'd1;
	end

	assign busy_dec = (busy_q[lane_q] != 16'd0) ? busy_q[lane_q] - 16'd1 : 16'd0;
	assign head_nx  = (head_q[lane_q] == QD_TOP) ? '0 : head_q[lane_q] + QW'(1);
	assign rd_addr  = AW'(lane_q) * QD_A + AW'(head_q[lane_q]);
	assign wr_addr  = AW'(lane_e) * QD_A + AW'(tail_q[lane_e]);

	assign out_free = !out_valid || out_ready;
	assign sts.is_tick    = (in_cmd == trrld_pkg::CMD_TICK);
	assign sts.grant_now  = (busy_dec == 16'd0) && (fill_q[lane_q] != '0);
	assign sts.lane_last  = (4'(lane_q) + 4'd1) == n_act;
	assign sts.out_free   = out_free;
	assign sts.pend_valid = pend_q;

	// queue memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.do_enq && found && fill_q[lane_e] < QD_F)
			mem[wr_addr] <= {iurg_q, icls_q, itag_q};
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept_in) begin
			icls_q <= in_cls; iurg_q <= in_urg; itag_q <= in_tag;
		end
	end

	assign out_load = cmd.do_enq || cmd.flush || (cmd.take_data && pend_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_count_q <= 4'd1;
			caps_q       <= 16'hFFFF;
			a_ticks_q    <= 16'd1;
			b_ticks_q    <= 16'd1;
			a_ptr_q      <= '0;
			b_ptr_q      <= '0;
			lane_q       <= '0;
			pend_q       <= 1'b0;
			out_valid    <= 1'b0;
			for (int i = 0; i < MAX_LANES; i++) begin
				head_q[i] <= '0; tail_q[i] <= '0; fill_q[i] <= '0; busy_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					8'(trrld_pkg::REG_LANE_COUNT): lane_count_q <= cfg_data[3:0];
					8'(trrld_pkg::REG_LANE_CAPS):  caps_q <= cfg_data;
					8'(trrld_pkg::REG_A_TICKS):    a_ticks_q <= cfg_data;
					8'(trrld_pkg::REG_B_TICKS):    b_ticks_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (out_load) out_valid <= 1'b1;
			if (cmd.lane_clr) lane_q <= '0;

			if (cmd.do_enq) begin
				if (!(iurg_q && icls_q)) begin
					if (icls_q) a_ptr_q <= ptr_nx;
					else b_ptr_q <= ptr_nx;
				end
				if (found && fill_q[lane_e] < QD_F) begin
					tail_q[lane_e] <= (tail_q[lane_e] == QD_TOP) ? '0 :
						tail_q[lane_e] + QW'(1);
					fill_q[lane_e] <= fill_q[lane_e] + FW'(1);
				end
			end

			if (cmd.scan_step && !sts.grant_now) begin
				busy_q[lane_q] <= busy_dec;
				lane_q <= lane_q + LW'(1);
			end

			if (cmd.take_data) begin
				busy_q[lane_q] <= rd_q[16] ? a_ticks_q : b_ticks_q;
				head_q[lane_q] <= head_nx;
				fill_q[lane_q] <= fill_q[lane_q] - FW'(1);
				pend_q      <= 1'b1;
				pend_lane_q <= lane_q;
				pend_tag_q  <= rd_q[15:0];
				pend_cls_q  <= rd_q[16];
				lane_q      <= lane_q + LW'(1);
			end
			if (cmd.flush) pend_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.do_enq) begin
			out_kind <= !found ? trrld_pkg::KIND_NO_LANE :
				(fill_q[lane_e] >= QD_F) ? trrld_pkg::KIND_FULL : trrld_pkg::KIND_OK;
			out_lane <= found ? 3'(lane_e) : 3'd0;
			out_tag  <= itag_q;
			out_cls  <= icls_q;
			out_last <= 1'b1;
		end else if (cmd.flush || (cmd.take_data && pend_q)) begin
			out_kind <= trrld_pkg::KIND_GRANT;
			out_lane <= 3'(pend_lane_q);
			out_tag  <= pend_tag_q;
			out_cls  <= pend_cls_q;
			out_last <= cmd.flush;
		end
	end

endmodule

// ----- sv/typed_round_robin_lane_dispatcher.sv -----
// Top level of the typed round-robin lane dispatcher.
//
// Requests enter on the s_ channel, results leave on the m_ channel, and the
// four registers are written on the cfg_ channel (always ready; write only
// while the block is idle).
// An enqueue request (tuser 0) picks a lane by capability, either the lowest
// compatible lane (urgent class A) or round robin from the class pointer, and
// returns exactly one result with tlast set: accepted, no lane or queue full.
// A tick request (tuser 1) walks lanes 0..n-1, one lane per cycle while no
// grant is made: count the busy counter down, and where the lane is free with
// a waiting request, read its queue head from the shared queue memory and
// grant it. Each grant passes through a read-data state for the registered
// memory read, which waits while a held grant cannot go out. Grants are held
// one deep so the last one can carry tlast; a tick with no grant returns nothing.
// One request is in work at a time; the result register lets the next request
// be taken while the previous result waits.
// When m_tready is low the block holds its result and stalls its sequence.
// Reset clears registers to their defaults, the pointers and all queues.
module typed_round_robin_lane_dispatcher #(
	parameter int MAX_LANES   = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // is_class_a, is_urgent, requester_tag[15:0]
	input  logic        s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // lane_index[2:0], granted_tag[15:0], granted_class_a
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast,   // last_result
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	trrld_pkg::cmd_t cmd;
	trrld_pkg::sts_t sts;
	logic [2:0]  o_lane;
	logic [15:0] o_tag;
	logic        o_cls;

	assign cfg_ready = 1'b1;

	trrld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	trrld_dp #(
		.MAX_LANES   (MAX_LANES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_cmd    (s_tuser),
		.in_cls    (s_tdata[0]),
		.in_urg    (s_tdata[1]),
		.in_tag    (s_tdata[17:2]),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_lane  (o_lane),
		.out_tag   (o_tag),
		.out_cls   (o_cls),
		.out_last  (m_tlast)
	);

	assign m_tdata = {4'd0, o_cls, o_tag, o_lane};

endmodule

// ----- sv/trrld_checker.sv -----
// Port-level checks of the lane dispatcher, bound to the top level.
module trrld_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while one is in work");

	a_enq_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != trrld_pkg::KIND_GRANT |-> m_tlast)
		else $error("enqueue result without tlast");

endmodule

bind typed_round_robin_lane_dispatcher trrld_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ----- bench/typed_round_robin_lane_dispatcher_chk.sv -----
// Result checker for the lane dispatcher: tracks lane state and compares every result.
`timescale 1ns / 100ps
module typed_round_robin_lane_dispatcher_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        m_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending_results
);
	localparam int LANES = 8;
	localparam int DEPTH = 16;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  lane;
		logic [15:0] tag;
		logic        cls_a;
		logic        last;
	} dispatch_res_t;

	logic [3:0]  lane_count_q;
	logic [15:0] caps_q;
	logic [15:0] a_ticks_q;
	logic [15:0] b_ticks_q;
	logic [2:0]  ptr_a;
	logic [2:0]  ptr_b;
	logic [17:0] qmem [LANES*DEPTH];
	logic [3:0]  qhead [LANES];
	logic [3:0]  qtail [LANES];
	logic [4:0]  qfill [LANES];
	logic [15:0] busy [LANES];
	dispatch_res_t due_results [$];

	function automatic int lanes_used();
		if (lane_count_q == 4'd0) return 1;
		if (lane_count_q > LANES) return LANES;
		return int'(lane_count_q);
	endfunction

	// predict one request and push its results
	task automatic dispatch_request(input logic cmd, input logic [23:0] d);
		int n;
		int p;
		int idx;
		int ln;
		int cnt;
		logic found;
		logic cls;
		logic urg;
		logic [15:0] tag;
		logic [17:0] e;
		dispatch_res_t r;
		n = lanes_used();
		cls = d[0];
		urg = d[1];
		tag = d[17:2];
		if (cmd == trrld_pkg::CMD_TICK) begin
			cnt = 0;
			for (int i = 0; i < n; i++) begin
				if (busy[i] > 0) busy[i]--;
				if (busy[i] == 0 && qfill[i] > 0) begin
					e = qmem[i*DEPTH + qhead[i]];
					qhead[i]++;
					qfill[i]--;
					busy[i] = e[16] ? a_ticks_q : b_ticks_q;
					r = '{trrld_pkg::KIND_GRANT, i[2:0], e[15:0], e[16], 1'b0};
					due_results.push_back(r);
					cnt++;
				end
			end
			if (cnt > 0) due_results[$].last = 1'b1;
		end else begin
			found = 0;
			ln = 0;
			if (urg && cls) begin
				for (int i = 0; i < n && !found; i++)
					if (caps_q[2*i]) begin
						ln = i;
						found = 1;
					end
			end else begin
				p = cls ? int'(ptr_a) : int'(ptr_b);
				if (p >= n) p = 0;
				for (int i = 0; i < n && !found; i++) begin
					idx = p;
					p = (idx + 1) % n;
					if (caps_q[2*idx + (cls ? 0 : 1)]) begin
						ln = idx;
						found = 1;
					end
				end
				if (cls) ptr_a = p[2:0];
				else ptr_b = p[2:0];
			end
			if (!found) r = '{trrld_pkg::KIND_NO_LANE, 3'd0, tag, cls, 1'b1};
			else if (qfill[ln] >= DEPTH) r = '{trrld_pkg::KIND_FULL, ln[2:0], tag, cls, 1'b1};
			else begin
				qmem[ln*DEPTH + qtail[ln]] = {urg, cls, tag};
				qtail[ln]++;
				qfill[ln]++;
				r = '{trrld_pkg::KIND_OK, ln[2:0], tag, cls, 1'b1};
			end
			due_results.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		dispatch_res_t got;
		dispatch_res_t want;
		if (!arst_n) begin
			lane_count_q = 4'd1;
			caps_q = 16'hFFFF;
			a_ticks_q = 16'd1;
			b_ticks_q = 16'd1;
			ptr_a = '0;
			ptr_b = '0;
			for (int i = 0; i < LANES; i++) begin
				qhead[i] = '0;
				qtail[i] = '0;
				qfill[i] = '0;
				busy[i] = '0;
			end
			due_results.delete();
			fail_count = 0;
			pending_results = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					8'(trrld_pkg::REG_LANE_COUNT): lane_count_q = cfg_data[3:0];
					8'(trrld_pkg::REG_LANE_CAPS):  caps_q = cfg_data;
					8'(trrld_pkg::REG_A_TICKS):    a_ticks_q = cfg_data;
					8'(trrld_pkg::REG_B_TICKS):    b_ticks_q = cfg_data;
					default: ;
				endcase
			end
			// compare result before predicting, a result never follows its request same edge
			if (m_tvalid && m_tready) begin
				got = '{m_tuser, m_tdata[2:0], m_tdata[18:3], m_tdata[19], m_tlast};
				if (due_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %h", got);
				end else begin
					want = due_results.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: expected kind %0d lane %0d tag %h a %b last %b,",
								" got kind %0d lane %0d tag %h a %b last %b"},
								want.kind, want.lane, want.tag, want.cls_a, want.last,
								got.kind, got.lane, got.tag, got.cls_a, got.last);
					end
				end
			end
			if (s_tvalid && s_tready) dispatch_request(s_tuser, s_tdata);
			pending_results = due_results.size();
		end
	end
endmodule

// ----- bench/typed_round_robin_lane_dispatcher_tb.sv -----
// Top of the lane dispatcher testbench: stimulus, configuration phases and verdict.
`timescale 1ns / 100ps
module typed_round_robin_lane_dispatcher_tb;

	localparam int WATCHDOG_LIMIT = 200000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tuser = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int          fail_count;
	int          pending_results;
	int          idle_cycles = 0;
	logic        stall_mode = 0;

	always #5 clk = ~clk;

	typed_round_robin_lane_dispatcher i_dut (.*);

	typed_round_robin_lane_dispatcher_chk i_chk (.*);

	// receiver: stall pattern with phases of full throughput
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
		m_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
	end

	// watchdog: count cycles with no handshake on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("typed_round_robin_lane_dispatcher_tb: errors");
				$finish;
			end
		end
	end

	// send one request, then drop valid unless the burst continues
	task automatic send_request(input logic cmd, input logic cls, input logic urg,
			input logic [15:0] tag, input logic hold);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {6'd0, tag, urg, cls};
		do @(posedge clk); while (!s_tready);
		if (!hold) s_tvalid <= 1'b0;
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// wait until all results are in, then let the last tick finish
	task automatic drain_results();
		while (pending_results != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic random_requests(input int count, input int tick_pct);
		int burst;
		burst = 0;
		for (int k = 0; k < count; k++) begin
			if (burst == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(0, 4)) @(posedge clk);
				burst = $urandom_range(1, 10);
			end
			burst--;
			send_request($urandom_range(0, 99) < tick_pct, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
				burst != 0 && k != count - 1);
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default single lane, fill the queue to overflow, then tick and wait for the results
		for (int k = 0; k < 17; k++)
			send_request(trrld_pkg::CMD_ENQUEUE, k[0], k[1],
				(k == 0) ? 16'h0000 : 16'(16'hFFFF - k), 1'b0);
		for (int k = 0; k < 3; k++)
			send_request(trrld_pkg::CMD_TICK, 1'b1, 1'b1, 16'hFFFF, 1'b0);
		drain_results();

		// no compatible lane, shrinking count, pointer reset, urgent path
		write_reg(8'(trrld_pkg::REG_LANE_COUNT), 16'd8);
		write_reg(8'(trrld_pkg::REG_LANE_CAPS), 16'h0000);
		send_request(trrld_pkg::CMD_ENQUEUE, 1'b1, 1'b0, 16'h1234, 1'b0);
		send_request(trrld_pkg::CMD_ENQUEUE, 1'b0, 1'b0, 16'h4321, 1'b0);
		send_request(trrld_pkg::CMD_ENQUEUE, 1'b1, 1'b1, 16'h5555, 1'b0);
		drain_results();
		write_reg(8'(trrld_pkg::REG_LANE_CAPS), 16'hA9C6);
		write_reg(8'(trrld_pkg::REG_A_TICKS), 16'd0);
		write_reg(8'(trrld_pkg::REG_B_TICKS), 16'd2);
		for (int k = 0; k < 5; k++)
			send_request(trrld_pkg::CMD_ENQUEUE, 1'b0, 1'b0, 16'(16'hB000 + k), 1'b0);
		drain_results();
		write_reg(8'(trrld_pkg::REG_LANE_COUNT), 16'd3);
		write_reg(8'd7, 16'hFFFF);
		send_request(trrld_pkg::CMD_ENQUEUE, 1'b0, 1'b0, 16'hC0DE, 1'b0);
		send_request(trrld_pkg::CMD_ENQUEUE, 1'b1, 1'b1, 16'hAAAA, 1'b0);
		for (int k = 0; k < 4; k++)
			send_request(trrld_pkg::CMD_TICK, 1'b0, 1'b0, 16'h0, 1'b0);
		drain_results();

		// random phases over several settings, extremes included
		write_reg(8'(trrld_pkg::REG_LANE_COUNT), 16'd8);
		write_reg(8'(trrld_pkg::REG_LANE_CAPS), 16'hFFFF);
		write_reg(8'(trrld_pkg::REG_A_TICKS), 16'd1);
		write_reg(8'(trrld_pkg::REG_B_TICKS), 16'd0);
		random_requests(40, 40);
		drain_results();
		write_reg(8'(trrld_pkg::REG_LANE_COUNT), 16'd15);
		write_reg(8'(trrld_pkg::REG_LANE_CAPS), 16'($urandom_range(0, 65535)));
		write_reg(8'(trrld_pkg::REG_A_TICKS), 16'd3);
		write_reg(8'(trrld_pkg::REG_B_TICKS), 16'd1);
		random_requests(40, 30);
		drain_results();
		write_reg(8'(trrld_pkg::REG_LANE_COUNT), 16'd0);
		write_reg(8'(trrld_pkg::REG_A_TICKS), 16'hFFFF);
		random_requests(25, 40);
		drain_results();
		write_reg(8'(trrld_pkg::REG_LANE_COUNT), 16'($urandom_range(2, 7)));
		write_reg(8'(trrld_pkg::REG_LANE_CAPS), 16'($urandom_range(0, 65535)));
		write_reg(8'(trrld_pkg::REG_A_TICKS), 16'd2);
		random_requests(30, 50);
		drain_results();

		if (fail_count == 0)
			$display("typed_round_robin_lane_dispatcher_tb: clean");
		else
			$display("typed_round_robin_lane_dispatcher_tb: errors");
		$finish;
	end
endmodule
